@@ sv/m4inv_pkg.sv @@
// ----------------------------------------------------------------------------
// m4inv_pkg
// shared constants and the cofactor term index table for the 4x4 inverse
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int W64      = 64;
    localparam int DIG_BITS = 8;

    localparam logic signed [W64-1:0] S64_MAX = {1'b0, {(W64-1){1'b1}}};
    localparam logic signed [W64-1:0] S64_MIN = {1'b1, {(W64-1){1'b0}}};

    // element index of factor k of minor term t for cofactor (r, c)
    function automatic logic [3:0] tri_idx(input logic [1:0] r, input logic [1:0] c,
                                           input logic [2:0] t, input logic [1:0] k);
        logic [1:0] col;
        logic [1:0] row;
        logic [1:0] mc;
        col = 2'd0;
        unique case (t)
            3'd0: col = k;
            3'd1: col = (k == 2'd0) ? 2'd0 : ((k == 2'd1) ? 2'd2 : 2'd1);
            3'd2: col = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd0 : 2'd2);
            3'd3: col = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd2 : 2'd0);
            3'd4: col = (k == 2'd0) ? 2'd2 : ((k == 2'd1) ? 2'd0 : 2'd1);
            3'd5: col = (k == 2'd0) ? 2'd2 : ((k == 2'd1) ? 2'd1 : 2'd0);
            default: col = 2'd0;
        endcase
        row = (k < r) ? k : k + 2'd1;
        mc  = (col < c) ? col : col + 2'd1;
        return {row, mc};
    endfunction

    // minor terms that enter with a minus sign
    function automatic logic term_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

@@ sv/m4inv_if.sv @@
// ----------------------------------------------------------------------------
// m4inv channel interfaces
// request channels for matrix elements in and inverse elements out
// ----------------------------------------------------------------------------
interface m4inv_in_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface m4inv_out_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] result;
    logic [3:0]              position;
    logic                    last;
    logic                    singular;

    modport source (output valid, output result, output position, output last,
                    output singular, input ready);
    modport sink   (input valid, input result, input position, input last,
                    input singular, output ready);
endinterface

@@ sv/matrix4_inverse_fixed.sv @@
// sequence: 16 element requests, then the cofactor work on the shared digit-serial
// multiplier, then, unless the determinant is zero, the sixteen divisions on the
// bit-serial divider
// throughput: one matrix at a time; no element is taken while a run computes or drains
// reset: clears the fill count and control; both stores keep their contents
// ----------------------------------------------------------------------------
// matrix4_inverse_fixed
// 4x4 fixed point inverse by cofactor expansion over an element and an adjugate store
// ----------------------------------------------------------------------------
module matrix4_inverse_fixed #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    m4inv_in_if.sink     i_in,
    m4inv_out_if.source  o_out
);
    import m4inv_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int NSTEP = (DW + DIG_BITS - 1) / DIG_BITS;
    localparam int PW    = W64 + NSTEP * DIG_BITS + 1;

    typedef enum logic [15:0] {
        S_FILL = 16'h0001, S_TA   = 16'h0002, S_TB   = 16'h0004, S_TC   = 16'h0008,
        S_M1   = 16'h0010, S_W1   = 16'h0020, S_M2   = 16'h0040, S_W2   = 16'h0080,
        S_FIN  = 16'h0100, S_DM   = 16'h0200, S_DW   = 16'h0400, S_NEXT = 16'h0800,
        S_ORD  = 16'h1000, S_DST  = 16'h2000, S_DWT  = 16'h4000, S_OUT  = 16'h8000
    } t_state;

    t_state                  r_state, n_state;
    logic [3:0]              r_fill, n_fill;
    logic [3:0]              r_n, n_n;
    logic [2:0]              r_t, n_t;
    logic [3:0]              r_k, n_k;
    logic signed [W64-1:0]   r_acc, n_acc;
    logic signed [W64-1:0]   r_det, n_det;
    logic signed [W64-1:0]   r_p, n_p;
    logic signed [DW-1:0]    r_opa, n_opa;
    logic signed [DW-1:0]    r_opb, n_opb;
    logic signed [DW-1:0]    r_opc, n_opc;
    logic signed [DW-1:0]    r_res, n_res;
    logic                    r_sing, n_sing;

    logic                    in_acc;
    logic [3:0]              el_raddr;
    logic signed [DW-1:0]    el_rdata;
    logic signed [W64-1:0]   adj_rdata;
    logic signed [W64-1:0]   fin_val;
    logic                    mul_start;
    logic signed [W64-1:0]   mul_a;
    logic signed [DW-1:0]    mul_b;
    logic                    mul_done;
    logic signed [PW-1:0]    mul_prod;
    logic signed [W64-1:0]   sat_raw;
    logic signed [W64-1:0]   sat_sh;
    logic signed [W64-1:0]   term;
    logic                    div_start;
    logic                    div_done;
    logic signed [DW-1:0]    div_quot;

    function automatic logic signed [W64-1:0] sat_p(input logic signed [PW-1:0] x);
        logic fit;
        fit = (&x[PW-1:W64-1]) | ~(|x[PW-1:W64-1]);
        return fit ? x[W64-1:0] : (x[PW-1] ? S64_MIN : S64_MAX);
    endfunction

    function automatic logic signed [W64-1:0] sadd(input logic signed [W64-1:0] a,
                                                   input logic signed [W64-1:0] b);
        logic signed [W64:0] s;
        s = {a[W64-1], a} + {b[W64-1], b};
        return (s[W64] != s[W64-1]) ? (s[W64] ? S64_MIN : S64_MAX) : s[W64-1:0];
    endfunction

    function automatic logic signed [W64-1:0] sneg(input logic signed [W64-1:0] a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    assign in_acc   = i_in.valid && i_in.ready;
    assign sat_raw  = sat_p(mul_prod);
    assign sat_sh   = sat_p(mul_prod >>> FRAC_BITS);
    assign term     = term_neg(r_t) ? sneg(sat_sh) : sat_sh;
    assign fin_val  = (r_n[0] ^ r_n[2]) ? sneg(r_acc) : r_acc;

    always_comb begin
        unique case (r_state)
            S_TA:    el_raddr = tri_idx(r_n[1:0], r_n[3:2], r_t, 2'd0);
            S_TB:    el_raddr = tri_idx(r_n[1:0], r_n[3:2], r_t, 2'd1);
            S_TC:    el_raddr = tri_idx(r_n[1:0], r_n[3:2], r_t, 2'd2);
            S_FIN:   el_raddr = {2'b00, r_n[3:2]};
            default: el_raddr = 4'd0;
        endcase
    end

    m4inv_ram #(.WIDTH(DW), .DEPTH(16)) u_elem (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill),
        .i_wdata (i_in.value),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    m4inv_ram #(.WIDTH(W64), .DEPTH(16)) u_adj (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FIN),
        .i_waddr (r_n),
        .i_wdata (fin_val),
        .i_raddr (r_k),
        .o_rdata (adj_rdata)
    );

    assign mul_start = (r_state == S_M1) || (r_state == S_M2) || (r_state == S_DM);

    always_comb begin
        unique case (r_state)
            S_M1: begin
                mul_a = W64'(r_opa);
                mul_b = r_opb;
            end
            S_M2: begin
                mul_a = r_p;
                mul_b = r_opc;
            end
            default: begin
                mul_a = r_acc;
                mul_b = el_rdata;
            end
        endcase
    end

    m4inv_mul #(.DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_op_a  (mul_a),
        .i_op_b  (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign div_start = (r_state == S_DST) && (r_det != '0);

    m4inv_div #(.DW(DW), .FRAC(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (adj_rdata),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_n     = r_n;
        n_t     = r_t;
        n_k     = r_k;
        n_acc   = r_acc;
        n_det   = r_det;
        n_p     = r_p;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_opc   = r_opc;
        n_res   = r_res;
        n_sing  = r_sing;
        unique case (r_state)
            S_FILL: begin
                if (in_acc) begin
                    n_fill = r_fill + 1'b1;
                    if (&r_fill) begin
                        n_n     = '0;
                        n_t     = '0;
                        n_acc   = '0;
                        n_det   = '0;
                        n_state = S_TA;
                    end
                end
            end
            S_TA: n_state = S_TB;
            S_TB: begin
                n_opa   = el_rdata;
                n_state = S_TC;
            end
            S_TC: begin
                n_opb   = el_rdata;
                n_state = S_M1;
            end
            S_M1: begin
                n_opc   = el_rdata;
                n_state = S_W1;
            end
            S_W1: begin
                if (mul_done) begin
                    n_p     = sat_raw;
                    n_state = S_M2;
                end
            end
            S_M2: n_state = S_W2;
            S_W2: begin
                if (mul_done) begin
                    n_acc = sadd(r_acc, term);
                    if (r_t == 3'd5) begin
                        n_state = S_FIN;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = S_TA;
                    end
                end
            end
            S_FIN: begin
                n_acc   = fin_val;
                n_state = (r_n[1:0] == 2'd0) ? S_DM : S_NEXT;
            end
            S_DM: n_state = S_DW;
            S_DW: begin
                if (mul_done) begin
                    n_det   = sadd(r_det, sat_sh);
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (&r_n) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_t     = '0;
                    n_acc   = '0;
                    n_state = S_TA;
                end
            end
            S_ORD: n_state = S_DST;
            S_DST: begin
                if (r_det == '0) begin
                    n_res   = '0;
                    n_sing  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_sing  = 1'b0;
                    n_state = S_DWT;
                end
            end
            S_DWT: begin
                if (div_done) begin
                    n_res   = div_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    if (&r_k) begin
                        n_fill  = '0;
                        n_state = S_FILL;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_n     <= '0;
            r_t     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_n     <= n_n;
            r_t     <= n_t;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_det  <= n_det;
        r_p    <= n_p;
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_opc  <= n_opc;
        r_res  <= n_res;
        r_sing <= n_sing;
    end

    assign i_in.ready     = (r_state == S_FILL);
    assign o_out.valid    = (r_state == S_OUT);
    assign o_out.result   = r_res;
    assign o_out.position = r_k;
    assign o_out.last     = &r_k;
    assign o_out.singular = r_sing;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_sides_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while results drain");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |-> (o_out.result == '0))
        else $error("singular run with non-zero result");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (&r_fill)) |=> (r_state == S_TA && r_n == '0 && r_t == '0))
        else $error("run did not start at first cofactor");
endmodule

@@ sv/m4inv_ram.sv @@
// ----------------------------------------------------------------------------
// m4inv_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ sv/m4inv_mul.sv @@
// ----------------------------------------------------------------------------
// m4inv_mul
// signed 64 x DW multiplier, one 8-bit digit of the second operand per cycle
// ----------------------------------------------------------------------------
module m4inv_mul #(
    parameter int DW = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [m4inv_pkg::W64-1:0]       i_op_a,
    input  logic signed [DW-1:0]                   i_op_b,
    output logic                                   o_done,
    output logic signed [m4inv_pkg::W64+((DW+m4inv_pkg::DIG_BITS-1)/m4inv_pkg::DIG_BITS)
                         *m4inv_pkg::DIG_BITS:0]  o_prod
);
    import m4inv_pkg::*;

    localparam int NSTEP = (DW + DIG_BITS - 1) / DIG_BITS;
    localparam int MW    = NSTEP * DIG_BITS;
    localparam int AW    = W64 + MW;
    localparam int CW    = $clog2(NSTEP + 1);

    logic [W64-1:0]          r_mcand;
    logic [MW-1:0]           r_mplier;
    logic [AW-1:0]           r_acc;
    logic                    r_neg;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic signed [AW:0]      r_prod;
    logic [W64-1:0]          mag_a;
    logic [DW-1:0]           mag_b;
    logic [W64+DIG_BITS-1:0] pp;

    assign mag_a = i_op_a[W64-1] ? W64'(-i_op_a) : W64'(i_op_a);
    assign mag_b = i_op_b[DW-1] ? DW'(-i_op_b) : DW'(i_op_b);
    assign pp    = r_mcand * r_mplier[MW-1 -: DIG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NSTEP);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= mag_a;
            r_mplier <= MW'(mag_b);
            r_acc    <= '0;
            r_neg    <= i_op_a[W64-1] ^ i_op_b[DW-1];
        end else if (r_busy) begin
            r_acc    <= (r_acc << DIG_BITS) + AW'(pp);
            r_mplier <= r_mplier << DIG_BITS;
        end
        if (r_fin) begin
            r_prod <= r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

@@ sv/m4inv_div.sv @@
// ----------------------------------------------------------------------------
// m4inv_div
// restoring divider, one quotient bit per cycle, scaled and saturated result
// ----------------------------------------------------------------------------
module m4inv_div #(
    parameter int DW   = 32,
    parameter int FRAC = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [m4inv_pkg::W64-1:0] i_num,
    input  logic signed [m4inv_pkg::W64-1:0] i_den,
    output logic                             o_done,
    output logic signed [DW-1:0]             o_quot
);
    import m4inv_pkg::*;

    localparam int NW = W64 + FRAC;
    localparam int CW = $clog2(NW + 1);
    localparam logic [DW-1:0] HALF = {1'b1, {(DW-1){1'b0}}};

    logic [NW-1:0]    r_num;
    logic [W64-1:0]   r_rem;
    logic [W64-1:0]   r_den;
    logic [NW-1:0]    r_q;
    logic             r_neg;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [DW-1:0]    r_quot;
    logic [W64:0]     rem_sh;
    logic             ge;
    logic [DW-1:0]    lim;
    logic [DW-1:0]    qs;
    logic [W64-1:0]   mag_n;
    logic [W64-1:0]   mag_d;

    assign mag_n  = i_num[W64-1] ? W64'(-i_num) : W64'(i_num);
    assign mag_d  = i_den[W64-1] ? W64'(-i_den) : W64'(i_den);
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign lim    = r_neg ? HALF : HALF - 1'b1;
    assign qs     = (r_q > NW'(lim)) ? lim : r_q[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NW'(mag_n) << FRAC;
            r_den <= mag_d;
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= i_num[W64-1] ^ i_den[W64-1];
        end else if (r_busy) begin
            r_rem <= ge ? W64'(rem_sh - {1'b0, r_den}) : W64'(rem_sh);
            r_q   <= {r_q[NW-2:0], ge};
            r_num <= r_num << 1;
        end
        if (r_fin) begin
            r_quot <= r_neg ? DW'(-qs) : qs;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// streams 4x4 fixed point matrices into the inverse block and checks every
// inverse element against a bit-exact cofactor/adjugate predictor, with
// random gaps on both request channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
    import m4inv_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int LIMIT     = 3000000;
    localparam int DRAIN     = 400;
    localparam logic signed [DW-1:0] ONE = 32'sh0001_0000;

    typedef logic signed [63:0]  s64_t;
    typedef logic signed [127:0] s128_t;
    typedef logic signed [DW-1:0] elem_t;

    typedef struct packed {
        logic signed [DW-1:0] result;
        logic [3:0]           position;
        logic                 last;
        logic                 singular;
    } inv_elem_t;

    logic i_clk;
    logic i_rst_n;

    m4inv_in_if  #(.WIDTH(DW)) elem_if ();
    m4inv_out_if #(.WIDTH(DW)) inv_if ();

    matrix4_inverse_fixed #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (elem_if),
        .o_out   (inv_if)
    );

    inv_elem_t inverse_q[$];
    elem_t     matrix_buf[16];
    int        fill_idx;
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic s64_t sat_wide(input s128_t x);
        if (x > s128_t'(S64_MAX)) return S64_MAX;
        if (x < s128_t'(S64_MIN)) return S64_MIN;
        return x[63:0];
    endfunction

    function automatic s64_t sat_add(input s64_t a, input s64_t b);
        s128_t wa, wb;
        wa = a;
        wb = b;
        return sat_wide(wa + wb);
    endfunction

    function automatic s64_t sat_neg(input s64_t a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    function automatic s64_t triple_prod(input s64_t a, input s64_t b, input s64_t c);
        s128_t wa, wb, wc, wp;
        wa = a;
        wb = b;
        wc = c;
        wp = sat_wide(wa * wb);
        return sat_wide((wp * wc) >>> FB);
    endfunction

    function automatic s64_t minor_cofactor(input elem_t m[16], input int r, input int c);
        int   rr[3], cc[3];
        int   n, k;
        s64_t e[3][3];
        s64_t acc;
        n = 0;
        k = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != r) begin rr[n] = i; n++; end
            if (i != c) begin cc[k] = i; k++; end
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                e[a][b] = m[rr[a]*4 + cc[b]];
        acc = triple_prod(e[0][0], e[1][1], e[2][2]);
        acc = sat_add(acc, sat_neg(triple_prod(e[0][0], e[1][2], e[2][1])));
        acc = sat_add(acc, sat_neg(triple_prod(e[0][1], e[1][0], e[2][2])));
        acc = sat_add(acc, triple_prod(e[0][1], e[1][2], e[2][0]));
        acc = sat_add(acc, triple_prod(e[0][2], e[1][0], e[2][1]));
        acc = sat_add(acc, sat_neg(triple_prod(e[0][2], e[1][1], e[2][0])));
        if ((r + c) % 2 == 1) acc = sat_neg(acc);
        return acc;
    endfunction

    function automatic elem_t scaled_quotient(input s64_t n, input s64_t d);
        s128_t wn, wd;
        logic [127:0] num, den, q, lim;
        logic neg;
        wn  = n;
        wd  = d;
        neg = (n < 0) != (d < 0);
        num = (wn < 0 ? -wn : wn) << FB;
        den = (wd < 0 ? -wd : wd);
        q   = num / den;
        lim = neg ? (128'd1 << (DW-1)) : ((128'd1 << (DW-1)) - 1);
        if (q > lim) q = lim;
        return neg ? -q[DW-1:0] : q[DW-1:0];
    endfunction

    task automatic predict_inverse(input elem_t m[16]);
        s64_t      adj[16];
        s64_t      det;
        s128_t     wp;
        inv_elem_t ex;
        det = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                adj[i*4 + j] = minor_cofactor(m, j, i);
        for (int j = 0; j < 4; j++) begin
            wp  = s128_t'(s64_t'(m[j])) * s128_t'(adj[j*4]);
            det = sat_add(det, sat_wide(wp >>> FB));
        end
        for (int i = 0; i < 16; i++) begin
            ex.singular = (det == 0);
            ex.result   = ex.singular ? '0 : scaled_quotient(adj[i], det);
            ex.position = i[3:0];
            ex.last     = (i == 15);
            inverse_q.push_back(ex);
        end
    endtask

    // ---------------- request drivers ----------------
    task automatic send_element(input elem_t v);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_if.valid = 1'b0;
            elem_if.value = $urandom;
            @(negedge i_clk);
        end
        elem_if.valid = 1'b1;
        elem_if.value = v;
        do @(posedge i_clk); while (!elem_if.ready);
        matrix_buf[fill_idx] = v;
        if (fill_idx == 15) begin
            fill_idx = 0;
            predict_inverse(matrix_buf);
        end else begin
            fill_idx++;
        end
    endtask

    task automatic send_matrix(input elem_t m[16]);
        for (int i = 0; i < 16; i++) send_element(m[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        elem_if.valid = 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // ---------------- matrix builders ----------------
    function automatic elem_t rand_small();
        return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endfunction

    task automatic build_random(output elem_t m[16]);
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 16; i++) begin
            case (kind)
                0, 1:    m[i] = $urandom;
                2:       m[i] = ($urandom_range(3) == 0) ? '0 : rand_small();
                3:       m[i] = elem_t'($signed($urandom_range(0, 512)) - 256);
                default: m[i] = rand_small() + ((i % 5 == 0) ? elem_t'(8 << FB) : '0);
            endcase
        end
        // duplicate row makes the matrix singular
        if (kind == 9)
            for (int j = 0; j < 4; j++) m[12 + j] = m[4 + j];
    endtask

    // ---------------- tests ----------------
    task automatic test_identity();
        elem_t m[16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : '0;
        send_matrix(m);
    endtask

    task automatic test_singular();
        elem_t m[16];
        for (int i = 0; i < 16; i++) m[i] = '0;
        send_matrix(m);
    endtask

    task automatic test_extremes();
        elem_t m[16];
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? elem_t'(32'sh8000_0000) :
                   ((i % 3 == 0) ? elem_t'(32'sh7fff_ffff) : elem_t'(i - 8));
        send_matrix(m);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        elem_t m[16];
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            build_random(m);
            send_matrix(m);
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        elem_t m[16];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 6000;
        for (int n = 0; n < 2; n++) begin
            build_random(m);
            send_matrix(m);
        end
        wait_idle();
    endtask

    // ---------------- receiver and checker ----------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles  = hold_cycles - 1;
            inv_if.ready = 1'b0;
        end else begin
            inv_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        inv_elem_t ex;
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("unexpected result", inv_if.result, 0);
            end else begin
                ex = inverse_q.pop_front();
                if (inv_if.result !== ex.result)
                    report_mismatch("result", inv_if.result, ex.result);
                if (inv_if.position !== ex.position)
                    report_mismatch("position", inv_if.position, ex.position);
                if (inv_if.last !== ex.last)
                    report_mismatch("last", inv_if.last, ex.last);
                if (inv_if.singular !== ex.singular)
                    report_mismatch("singular", inv_if.singular, ex.singular);
            end
        end
    end

    initial begin
        cycle_count    = 0;
        error_count    = 0;
        fill_idx       = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        elem_if.valid  = 1'b0;
        elem_if.value  = '0;
        inv_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_identity();
        test_singular();
        test_extremes();
        wait_idle();
        test_random(7, 0, 0);
        test_random(7, 67, 0);
        test_random(7, 0, 67);
        test_random(7, 36, 36);
        test_backpressure();

        if (inverse_q.size() != 0)
            report_mismatch("results missing", inverse_q.size(), 0);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
